### hdl/hlsc_pkg.sv
// hlsc_pkg: shared types, register codes, reset values, widths and rounding and
// saturation helpers of the high-pass and table waveshaper channel. No dependencies.
`default_nettype none

package hlsc_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 32;
	localparam int GAIN_W     = 24;
	localparam int TIDX_W     = 10;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 64;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 24;
	localparam int M_TUSER_W  = 1;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 33;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = PROD_W + 1;
	localparam int STATE_W = 40;
	localparam int Y_W     = 32;
	localparam int V_W     = 25;
	localparam int FRAC_W  = 25;
	localparam int DIFF_W  = 25;
	localparam int W_W     = 26;

	localparam logic [REG_IDX_W-1:0] REG_COEF_B0     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B1     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_B2     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A1     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A2     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SCALE = 3'd6;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_B0,
		OP_B1,
		OP_B2,
		OP_A1,
		OP_A2,
		OP_DRV,
		OP_POS,
		OP_INT,
		OP_SCL
	} mul_op_t;

	typedef struct packed {
		mul_op_t op;
		logic    ld_in;
		logic    tbl_we;
		logic    rd_en;
		logic    rd_hi;
		logic    ld_t0;
		logic    ld_diff;
		logic    ld_out;
	} hlsc_cmd_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic [GAIN_W-1:0]        drive;
		logic [SAMPLE_W-1:0]      scale;
	} hlsc_cfg_t;

	localparam hlsc_cfg_t CFG_RESET = '{
		b0:    32'sd268435456,
		b1:    32'sd0,
		b2:    32'sd0,
		a1:    32'sd0,
		a2:    32'sd0,
		drive: 24'd827392,
		scale: 24'd8388608
	};

	typedef logic signed [WIDE_W-1:0] wide_t;

	// round half up then drop n fraction bits
	function automatic wide_t rnd_sh(input wide_t v, input int unsigned n);
		wide_t half;
		half = wide_t'(1) <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic wide_t sat_to(input wide_t v, input int unsigned bits);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/hpf_lut_saturation_channel_core.sv
// hpf_lut_saturation_channel_core: top level of the stereo high-pass and
// interpolated table waveshaper. Depends on hlsc_pkg, hlsc_regs, hlsc_ctrl, hlsc_dp.
//
// Usage:
//   s_* carries requests: s_tuser[0] = 0 processes a sample, 1 writes a table
//   word. A table write is taken while idle and gives no result; the block
//   stays ready. A sample request runs through one shared 32x33 multiplier,
//   nine products in turn, plus two reads of the single-port table memory;
//   m_tvalid rises as the result is loaded and the block goes back to idle;
//   a new sample is taken only after the last has reached the output register.
//   The result sits in an output register; a stalled m_tready holds it, and
//   the next sample is taken and worked on meanwhile, waiting at its last
//   step until the register is free.
//   cfg_* writes registers 0..6 (b0, b1, b2, a1, a2, drive, output scale);
//   cfg_ready is always high. Write them only while idle.
//   Reset clears the filter state of every channel and loads the register
//   defaults. The table is not cleared: an entry must be written before a
//   sample reads it.
`default_nettype none

module hpf_lut_saturation_channel_core import hlsc_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int CHANNELS      = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // sample_in, table_index, table_value, zero pad
	input  wire logic [S_TUSER_W-1:0]  s_tuser,   // action, channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // sample_out
	output logic [M_TUSER_W-1:0]       m_tuser,   // channel_out
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	hlsc_cfg_t                  cfg;
	hlsc_cmd_t                  cmd;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic signed [SAMPLE_W-1:0] in_tval;
	logic [TIDX_W-1:0]          in_tidx;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       out_channel;

	assign in_sample = s_tdata[SAMPLE_W-1:0];
	assign in_tidx   = s_tdata[SAMPLE_W+TIDX_W-1:SAMPLE_W];
	assign in_tval   = s_tdata[2*SAMPLE_W+TIDX_W-1:SAMPLE_W+TIDX_W];

	hlsc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hlsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.in_action (s_tuser[0]),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd)
	);

	hlsc_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.CHANNELS      (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.in_channel  (s_tuser[1]),
		.in_sample   (in_sample),
		.in_tidx     (in_tidx),
		.in_tval     (in_tval),
		.out_channel (out_channel),
		.out_sample  (out_sample)
	);

	assign m_tdata = out_sample;
	assign m_tuser = out_channel;

	// a sample request keeps the block busy in the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser[0]) |=> !s_tready)
		else $error("block ready right after taking a sample");

	// a table write leaves the block ready
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> s_tready)
		else $error("block busy after a table write");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!m_tvalid || m_tready))
		else $error("output register loaded while full");

	// memory port is not read during a table write
	a_port_shared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_we |-> (!cmd.rd_en && cmd.op == OP_NONE))
		else $error("table write while a sample is in flight");

endmodule

`default_nettype wire

### hdl/hlsc_regs.sv
// hlsc_regs: configuration register bank written over the cfg request channel.
// Depends on hlsc_pkg for register codes, reset values and the hlsc_cfg_t type.
`default_nettype none

module hlsc_regs import hlsc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output hlsc_cfg_t                  cfg
);

	hlsc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COEF_B0:      cfg_q.b0 <= cfg_data;
				REG_COEF_B1:      cfg_q.b1 <= cfg_data;
				REG_COEF_B2:      cfg_q.b2 <= cfg_data;
				REG_COEF_A1:      cfg_q.a1 <= cfg_data;
				REG_COEF_A2:      cfg_q.a2 <= cfg_data;
				REG_DRIVE_GAIN:   cfg_q.drive <= cfg_data[GAIN_W-1:0];
				REG_OUTPUT_SCALE: cfg_q.scale <= cfg_data[SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/hlsc_ctrl.sv
// hlsc_ctrl: sequencer of the channel; steps one sample through the shared
// multiplier, table reads and output register. Depends on hlsc_pkg.
`default_nettype none

module hlsc_ctrl import hlsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic in_action,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output hlsc_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_A1,
		ST_A2,
		ST_DRV,
		ST_WAIT_V,
		ST_POS,
		ST_WAIT_P,
		ST_RD_LO,
		ST_RD_HI,
		ST_DIFF,
		ST_INT,
		ST_WAIT_W,
		ST_SCL,
		ST_WAIT_R,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= (m_valid_q && !m_tready) || ((state_q == ST_OUT) && out_free);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && !in_action) begin
						state_q <= ST_B0;
					end
				end
				ST_B0:     state_q <= ST_B1;
				ST_B1:     state_q <= ST_B2;
				ST_B2:     state_q <= ST_A1;
				ST_A1:     state_q <= ST_A2;
				ST_A2:     state_q <= ST_DRV;
				ST_DRV:    state_q <= ST_WAIT_V;
				ST_WAIT_V: state_q <= ST_POS;
				ST_POS:    state_q <= ST_WAIT_P;
				ST_WAIT_P: state_q <= ST_RD_LO;
				ST_RD_LO:  state_q <= ST_RD_HI;
				ST_RD_HI:  state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_INT;
				ST_INT:    state_q <= ST_WAIT_W;
				ST_WAIT_W: state_q <= ST_SCL;
				ST_SCL:    state_q <= ST_WAIT_R;
				ST_WAIT_R: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd    = '0;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ld_in  = s_tvalid && !in_action;
				cmd.tbl_we = s_tvalid && in_action;
			end
			ST_B0:  cmd.op = OP_B0;
			ST_B1:  cmd.op = OP_B1;
			ST_B2:  cmd.op = OP_B2;
			ST_A1:  cmd.op = OP_A1;
			ST_A2:  cmd.op = OP_A2;
			ST_DRV: cmd.op = OP_DRV;
			ST_POS: cmd.op = OP_POS;
			ST_RD_LO: begin
				cmd.rd_en = 1'b1;
			end
			ST_RD_HI: begin
				cmd.rd_en = 1'b1;
				cmd.rd_hi = 1'b1;
				cmd.ld_t0 = 1'b1;
			end
			ST_DIFF: cmd.ld_diff = 1'b1;
			ST_INT:  cmd.op = OP_INT;
			ST_SCL:  cmd.op = OP_SCL;
			ST_OUT:  cmd.ld_out = out_free;
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

### hdl/hlsc_dp.sv
// hlsc_dp: datapath with the shared multiplier, biquad state, transfer table
// memory, interpolation and output register. Depends on hlsc_pkg.
`default_nettype none

module hlsc_dp import hlsc_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int CHANNELS      = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire hlsc_cfg_t                  cfg,
	input  wire hlsc_cmd_t                  cmd,
	input  wire logic                       in_channel,
	input  wire logic signed [SAMPLE_W-1:0] in_sample,
	input  wire logic [TIDX_W-1:0]          in_tidx,
	input  wire logic signed [SAMPLE_W-1:0] in_tval,
	output logic                            out_channel,
	output logic signed [SAMPLE_W-1:0]      out_sample
);

	localparam int TIW    = $clog2(TABLE_ENTRIES);
	localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDXF_W = PROD_W - 1 - 24;

	localparam logic [CHW:0]                 CH_MAX    = (CHW + 1)'(CHANNELS - 1);
	localparam logic [TIW-1:0]               IDX_TOP   = TIW'(TABLE_ENTRIES - 2);
	localparam logic [IDXF_W-1:0]            IDX_LAST  = IDXF_W'(TABLE_ENTRIES - 1);
	localparam logic signed [MUL_B_W-1:0]    POS_SCALE = MUL_B_W'(TABLE_ENTRIES - 1);
	localparam logic [FRAC_W-1:0]            FRAC_ONE  = FRAC_W'(1) << (FRAC_W - 1);
	localparam logic [V_W-1:0]               V_OFFSET  = V_W'(8388608);
	localparam wide_t                        V_MAX     = wide_t'(8388608);
	localparam wide_t                        V_MIN     = -V_MAX;

	// request fields
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       chan_q;
	logic [CHW-1:0]             cs_q;
	logic [CHW:0]               ch_ext;

	// filter
	logic signed [Y_W-1:0]     y_q;
	logic signed [PROD_W-1:0]  acc1_q;
	logic signed [PROD_W-1:0]  acc2_q;
	logic signed [STATE_W-1:0] st1_q [CHANNELS];
	logic signed [STATE_W-1:0] st2_q [CHANNELS];

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	mul_op_t                   op_s1;

	// shaper
	logic signed [V_W-1:0]      v_q;
	logic [V_W-1:0]             u;
	logic [TIW-1:0]             idx_q;
	logic [FRAC_W-1:0]          frac_q;
	logic [IDXF_W-1:0]          idx_full;
	logic signed [SAMPLE_W-1:0] mem [TABLE_ENTRIES];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SAMPLE_W-1:0] t0_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [W_W-1:0]      w_q;
	logic signed [SAMPLE_W-1:0] r_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_chan_q;
	logic [TIW-1:0]             rd_addr;
	logic [TIW-1:0]             wr_addr;
	logic                       wr_ok;

	// post-multiply arithmetic
	wide_t pw;
	wide_t y_w;
	wide_t n1_w;
	wide_t n2_w;
	wide_t v_w;
	wide_t v_c;
	wide_t w_w;
	wide_t r_w;

	assign ch_ext   = (CHW + 1)'(in_channel);
	assign u        = V_W'(v_q) + V_OFFSET;
	assign wr_ok    = (32'(in_tidx) < 32'(TABLE_ENTRIES));
	assign wr_addr  = TIW'(in_tidx);
	assign rd_addr  = cmd.rd_hi ? TIW'(idx_q + TIW'(1)) : idx_q;
	assign idx_full = prod_s1[PROD_W-2:24];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_B0: begin
				mul_a = cfg.b0;
				mul_b = MUL_B_W'(x_q);
			end
			OP_B1: begin
				mul_a = cfg.b1;
				mul_b = MUL_B_W'(x_q);
			end
			OP_B2: begin
				mul_a = cfg.b2;
				mul_b = MUL_B_W'(x_q);
			end
			OP_A1: begin
				mul_a = cfg.a1;
				mul_b = MUL_B_W'(y_q);
			end
			OP_A2: begin
				mul_a = cfg.a2;
				mul_b = MUL_B_W'(y_q);
			end
			OP_DRV: begin
				mul_a = y_q;
				mul_b = MUL_B_W'(cfg.drive);
			end
			OP_POS: begin
				mul_a = MUL_A_W'(u);
				mul_b = POS_SCALE;
			end
			OP_INT: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(frac_q);
			end
			OP_SCL: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'(cfg.scale);
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign pw   = wide_t'(prod_s1);
	assign y_w  = sat_to(rnd_sh(pw, 28) + wide_t'(st1_q[cs_q]), Y_W);
	assign n1_w = sat_to(rnd_sh(wide_t'(acc1_q) - pw, 28) + wide_t'(st2_q[cs_q]), STATE_W);
	assign n2_w = sat_to(rnd_sh(wide_t'(acc2_q) - pw, 28), STATE_W);
	assign v_w  = rnd_sh(pw, 18);
	assign v_c  = (v_w > V_MAX) ? V_MAX : ((v_w < V_MIN) ? V_MIN : v_w);
	assign w_w  = wide_t'(t0_q) + rnd_sh(pw, 24);
	assign r_w  = sat_to(rnd_sh(pw, 23), SAMPLE_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			for (int i = 0; i < CHANNELS; i++) begin
				st1_q[i] <= '0;
				st2_q[i] <= '0;
			end
		end else begin
			op_s1 <= cmd.op;
			if (op_s1 == OP_A1) begin
				st1_q[cs_q] <= n1_w[STATE_W-1:0];
			end
			if (op_s1 == OP_A2) begin
				st2_q[cs_q] <= n2_w[STATE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (cmd.ld_in) begin
			x_q    <= in_sample;
			chan_q <= in_channel;
			cs_q   <= (ch_ext > CH_MAX) ? CH_MAX[CHW-1:0] : ch_ext[CHW-1:0];
		end
		unique case (op_s1)
			OP_B0:  y_q <= y_w[Y_W-1:0];
			OP_B1:  acc1_q <= prod_s1;
			OP_B2:  acc2_q <= prod_s1;
			OP_DRV: v_q <= v_c[V_W-1:0];
			OP_POS: begin
				// top of the range lands on the last word
				if (idx_full >= IDX_LAST) begin
					idx_q  <= IDX_TOP;
					frac_q <= FRAC_ONE;
				end else begin
					idx_q  <= TIW'(idx_full);
					frac_q <= {1'b0, prod_s1[23:0]};
				end
			end
			OP_INT: w_q <= w_w[W_W-1:0];
			OP_SCL: r_q <= r_w[SAMPLE_W-1:0];
			default: begin
			end
		endcase
		if (cmd.ld_t0) begin
			t0_q <= rd_q;
		end
		if (cmd.ld_diff) begin
			diff_q <= DIFF_W'(rd_q) - DIFF_W'(t0_q);
		end
		if (cmd.ld_out) begin
			out_sample_q <= r_q;
			out_chan_q   <= chan_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_we && wr_ok) begin
			mem[wr_addr] <= in_tval;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign out_channel = out_chan_q;
	assign out_sample  = out_sample_q;

endmodule

`default_nettype wire

### bench/hpf_lut_saturation_channel_core_tb.sv
// hpf_lut_saturation_channel_core_tb: self-checking bench for the stereo high-pass and
// interpolated table waveshaper; a bit-exact predictor checks every result in order.
// Depends on hlsc_pkg and the hpf_lut_saturation_channel_core rtl.
`default_nettype none

module hpf_lut_saturation_channel_core_tb;
	import hlsc_pkg::*;

	localparam int LUT_ENTRIES = 1024;
	localparam int NUM_CHANNELS = 2;
	localparam int SETTLE_CYCLES = 24;
	localparam bit ACT_SAMPLE = 1'b0;
	localparam bit ACT_LUT_WRITE = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint ONE_Q23 = 64'sd8388608;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7fffff;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
	localparam logic [COEF_W-1:0] COEF_MAX = 32'h7fffffff;
	localparam logic [COEF_W-1:0] COEF_MIN = 32'h80000000;
	// gentle second-order high-pass, q4.28
	localparam longint HP_B0 = 263066746;
	localparam longint HP_B1 = -526133493;
	localparam longint HP_A1 = -526133493;
	localparam longint HP_A2 = 257698038;

	typedef struct {
		bit                          action;
		bit                          chan;
		logic signed [SAMPLE_W-1:0]  smp;
		logic [TIDX_W-1:0]           tidx;
		logic signed [SAMPLE_W-1:0]  tval;
	} shaper_req_t;

	typedef struct {
		logic                 chan;
		logic [SAMPLE_W-1:0]  smp;
	} shaped_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // sample_in, table_index, table_value, zero pad
	logic [S_TUSER_W-1:0]  s_tuser;   // action, channel
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // sample_out
	logic [M_TUSER_W-1:0]  m_tuser;   // channel_out
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hpf_lut_saturation_channel_core #(
		.TABLE_ENTRIES(LUT_ENTRIES),
		.CHANNELS(NUM_CHANNELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	longint cb0, cb1, cb2, ca1, ca2, drive, oscale;
	longint hp_s1 [NUM_CHANNELS];
	longint hp_s2 [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] lut [LUT_ENTRIES];
	bit lut_set [LUT_ENTRIES];

	shaped_t shaped_q [$];
	shaped_t want;
	int errors;
	bit no_gaps;
	int unsigned stall;

	initial clk = 1'b0;

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("hpf_lut_saturation_channel_core verification failed");
		$finish;
	end

	function automatic longint rnd_half(input longint v, input int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) begin
			return hi;
		end else if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic longint hp_out(input bit ch, input longint x);
		return clip(rnd_half(cb0 * x, 28) + hp_s1[ch], 32);
	endfunction

	function automatic longint drive_level(input longint y);
		longint v;
		v = rnd_half(y * drive, 18);
		if (v > ONE_Q23) begin
			v = ONE_Q23;
		end else if (v < -ONE_Q23) begin
			v = -ONE_Q23;
		end
		return v;
	endfunction

	// lower table slot and q0.24 weight of the upper one; the top position reads the last word
	function automatic int unsigned lut_slot(input longint v, output longint frac);
		longint pos;
		longint slot;
		pos = (v + ONE_Q23) * (LUT_ENTRIES - 1);
		slot = pos >>> 24;
		frac = pos & 64'hffffff;
		if (slot >= LUT_ENTRIES - 1) begin
			slot = LUT_ENTRIES - 2;
			frac = longint'(1) << 24;
		end
		return int'(slot);
	endfunction

	function automatic logic [SAMPLE_W-1:0] shape_sample(input bit ch, input longint x);
		longint y, v, frac, t0, t1, w;
		int unsigned slot;
		y = hp_out(ch, x);
		hp_s1[ch] = clip(rnd_half(cb1 * x - ca1 * y, 28) + hp_s2[ch], STATE_W);
		hp_s2[ch] = clip(rnd_half(cb2 * x - ca2 * y, 28), STATE_W);
		v = drive_level(y);
		slot = lut_slot(v, frac);
		t0 = lut[slot];
		t1 = lut[slot + 1];
		w = t0 + rnd_half((t1 - t0) * frac, 24);
		return SAMPLE_W'(clip(rnd_half(w * oscale, 23), SAMPLE_W));
	endfunction

	function automatic shaper_req_t mk_write(input int unsigned idx, input logic [SAMPLE_W-1:0] val);
		shaper_req_t rq;
		rq.action = ACT_LUT_WRITE;
		rq.chan = 1'($urandom_range(0, 1));
		rq.smp = SAMPLE_W'($urandom);
		rq.tidx = TIDX_W'(idx);
		rq.tval = val;
		return rq;
	endfunction

	function automatic shaper_req_t mk_sample(input bit ch, input logic [SAMPLE_W-1:0] x);
		shaper_req_t rq;
		rq.action = ACT_SAMPLE;
		rq.chan = ch;
		rq.smp = x;
		rq.tidx = TIDX_W'($urandom);
		rq.tval = SAMPLE_W'($urandom);
		return rq;
	endfunction

	// called and returns at a falling edge
	task automatic push_request(input shaper_req_t rq);
		int unsigned gap;
		shaped_t res;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = {rq.chan, rq.action};
		s_tdata = {6'd0, rq.tval, rq.tidx, rq.smp};
		do @(posedge clk); while (!s_tready);
		if (rq.action == ACT_LUT_WRITE) begin
			lut[rq.tidx] = rq.tval;
			lut_set[rq.tidx] = 1'b1;
		end else begin
			res.chan = rq.chan;
			res.smp = shape_sample(rq.chan, rq.smp);
			shaped_q = {shaped_q, res};
		end
		@(negedge clk);
	endtask

	// fills whichever of the two table words the sample will read are still unset, before sending it
	task automatic send_sample(input bit ch, input logic signed [SAMPLE_W-1:0] x);
		longint frac;
		int unsigned slot;
		slot = lut_slot(drive_level(hp_out(ch, x)), frac);
		for (int k = 0; k < 2; k++) begin
			if (!lut_set[slot + k]) begin
				push_request(mk_write(slot + k, SAMPLE_W'($urandom)));
			end
		end
		push_request(mk_sample(ch, x));
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (shaped_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COEF_B0: cb0 = $signed(data);
			REG_COEF_B1: cb1 = $signed(data);
			REG_COEF_B2: cb2 = $signed(data);
			REG_COEF_A1: ca1 = $signed(data);
			REG_COEF_A2: ca2 = $signed(data);
			REG_DRIVE_GAIN: drive = data[GAIN_W-1:0];
			REG_OUTPUT_SCALE: oscale = data[SAMPLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_regs(input logic [CFG_DATA_W-1:0] b0, input logic [CFG_DATA_W-1:0] b1,
			input logic [CFG_DATA_W-1:0] b2, input logic [CFG_DATA_W-1:0] a1,
			input logic [CFG_DATA_W-1:0] a2, input logic [CFG_DATA_W-1:0] drv,
			input logic [CFG_DATA_W-1:0] scl);
		write_reg(REG_COEF_B0, b0);
		write_reg(REG_COEF_B1, b1);
		write_reg(REG_COEF_B2, b2);
		write_reg(REG_COEF_A1, a1);
		write_reg(REG_COEF_A2, a2);
		write_reg(REG_DRIVE_GAIN, drv);
		write_reg(REG_OUTPUT_SCALE, scl);
	endtask

	task automatic test_reset_defaults();
		push_request(mk_write(0, SMP_MIN));
		push_request(mk_write(LUT_ENTRIES - 1, SMP_MAX));
		push_request(mk_write(LUT_ENTRIES - 2, SMP_MIN));
		send_sample(1'b0, SMP_MAX);
		send_sample(1'b1, SMP_MIN);
		send_sample(1'b0, 24'sd0);
		send_sample(1'b1, 24'sd0);
		send_sample(1'b0, 24'sd1);
		send_sample(1'b1, -24'sd1);
		send_sample(1'b0, SMP_MIN);
		send_sample(1'b1, SMP_MAX);
		send_sample(1'b0, 24'sd1000000);
		send_sample(1'b1, -24'sd2000000);
		drain();
	endtask

	task automatic test_register_extremes();
		// saturating filter, full drive and scale
		load_regs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, 32'h00ffffff, 32'd8388608);
		write_reg(REG_UNUSED, $urandom);
		for (int i = 0; i < 6; i++) begin
			send_sample(i[0], i[1] ? SMP_MAX : SMP_MIN);
		end
		drain();
		// zero drive pins the centre slot, zero scale silences
		load_regs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 32'd0, 32'd0);
		for (int i = 0; i < 6; i++) begin
			send_sample(i[0], SAMPLE_W'($urandom));
		end
		drain();
		load_regs(32'(HP_B0), 32'(HP_B1), 32'(HP_B0), 32'(HP_A1), 32'(HP_A2),
			32'd262144, 32'd4194304);
		for (int i = 0; i < 6; i++) begin
			send_sample(i[1], SAMPLE_W'($urandom));
		end
		drain();
	endtask

	task automatic test_random_mix(input int phases, input int per_phase);
		logic [CFG_DATA_W-1:0] jit;
		for (int ph = 0; ph < phases; ph++) begin
			no_gaps = (ph == 1);
			if ($urandom_range(0, 3) == 0) begin
				load_regs($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 24'hffffff), $urandom_range(0, 8388608));
			end else begin
				jit = $urandom_range(0, 2097152);
				load_regs(32'(HP_B0 + jit - 1048576), 32'(HP_B1 - jit + 1048576),
					32'(HP_B0 + jit - 1048576),
					32'(HP_A1 + jit - 1048576), 32'(HP_A2 - jit + 1048576),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hffffff)
						: $urandom_range(65536, 1048576),
					$urandom_range(0, 8388608));
			end
			for (int i = 0; i < per_phase; i++) begin
				case ($urandom_range(0, 7))
					0, 1: push_request(mk_write($urandom_range(0, LUT_ENTRIES - 1),
						SAMPLE_W'($urandom)));
					2, 3: send_sample(1'($urandom_range(0, 1)),
						$signed(24'($urandom_range(0, 524288))) - 24'sd262144);
					default: send_sample(1'($urandom_range(0, 1)), SAMPLE_W'($urandom));
				endcase
			end
			drain();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (shaped_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h/%h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = shaped_q.pop_front();
				if (m_tuser !== want.chan) begin
					$display("%0t: channel_out expected %0d actual %0d", $time, want.chan, m_tuser);
					errors++;
				end
				if (m_tdata !== want.smp) begin
					$display("%0t: sample_out expected %h actual %h", $time, want.smp, m_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 18);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		errors = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cb0 = 268435456;
		cb1 = 0;
		cb2 = 0;
		ca1 = 0;
		ca2 = 0;
		drive = 827392;
		oscale = 8388608;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			hp_s1[c] = 0;
			hp_s2[c] = 0;
		end
		for (int i = 0; i < LUT_ENTRIES; i++) begin
			lut[i] = '0;
			lut_set[i] = 1'b0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_mix(5, 170);
		if (errors == 0) begin
			$display("hpf_lut_saturation_channel_core verification clean");
		end else begin
			$display("hpf_lut_saturation_channel_core verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
